// ===== rtl/c80alu_pkg.sv =====
// Shared types, operation codes and constants of the 8080-class accumulator and flag unit.
`timescale 1ns / 1ps

package c80alu_pkg;

    typedef enum logic [4:0] {
        ACT_ADD  = 5'd0,
        ACT_ADC  = 5'd1,
        ACT_SUB  = 5'd2,
        ACT_SBB  = 5'd3,
        ACT_AND  = 5'd4,
        ACT_XOR  = 5'd5,
        ACT_OR   = 5'd6,
        ACT_CMP  = 5'd7,
        ACT_RLC  = 5'd8,
        ACT_RRC  = 5'd9,
        ACT_RAL  = 5'd10,
        ACT_RAR  = 5'd11,
        ACT_CMA  = 5'd12,
        ACT_STC  = 5'd13,
        ACT_CMC  = 5'd14,
        ACT_DAA  = 5'd15,
        ACT_INR  = 5'd16,
        ACT_DCR  = 5'd17,
        ACT_LOAD = 5'd18
    } action_t;

    // accumulator plus the five flags
    typedef struct packed {
        logic [7:0] acc;
        logic       cy;
        logic       ac;
        logic       z;
        logic       s;
        logic       p;
    } alu_state_t;

    localparam logic [3:0] NIBBLE_MAX = 4'd9;
    localparam logic [8:0] DAA_LO_ADJ = 9'h006;
    localparam logic [8:0] DAA_HI_ADJ = 9'h060;

    // register index taken from paddr[2]
    localparam logic CFG_IDX_AND_HC = 1'b0;

endpackage

// ===== rtl/c80alu_exec.sv =====
// Combinational operation and flag logic of the accumulator unit.
`timescale 1ns / 1ps

module c80alu_exec
    import c80alu_pkg::*;
(
    input  logic [4:0]  action,
    input  logic [7:0]  operand,
    input  logic        and_hc_mode,
    input  alu_state_t  cur,
    output alu_state_t  nxt,
    output logic [7:0]  written
);

    logic       add_cin;
    logic       sub_cin;
    logic [8:0] sum9;
    logic [4:0] nib_sum;
    logic [8:0] diff9;
    logic [4:0] nib_diff;
    logic [7:0] and_val;
    logic [7:0] inr_val;
    logic [7:0] dcr_val;
    logic       daa_lo_fix;
    logic [8:0] daa_a1;
    logic       daa_ac;
    logic       daa_cy1;
    logic       daa_hi_fix;
    logic [8:0] daa_a2;
    logic       daa_cy;
    logic       wr_other;
    logic [7:0] wr_val;

    function automatic alu_state_t set_szp(alu_state_t st, logic [7:0] v);
        alu_state_t r;
        r   = st;
        r.z = (v == 8'h00);
        r.s = v[7];
        r.p = ~^v;
        return r;
    endfunction

    assign add_cin = (action_t'(action) == ACT_ADC) ? cur.cy : 1'b0;
    assign sub_cin = (action_t'(action) == ACT_SBB) ? cur.cy : 1'b0;

    assign sum9     = {1'b0, cur.acc} + {1'b0, operand} + {8'h00, add_cin};
    assign nib_sum  = {1'b0, cur.acc[3:0]} + {1'b0, operand[3:0]} + {4'h0, add_cin};
    // bit 8 / bit 4 of the differences is the borrow
    assign diff9    = {1'b0, cur.acc} - {1'b0, operand} - {8'h00, sub_cin};
    assign nib_diff = {1'b0, cur.acc[3:0]} - {1'b0, operand[3:0]} - {4'h0, sub_cin};

    assign and_val = cur.acc & operand;
    assign inr_val = operand + 8'd1;
    assign dcr_val = operand - 8'd1;

    // decimal adjust: low nibble fix, then high nibble fix
    assign daa_lo_fix = (cur.acc[3:0] > NIBBLE_MAX) || cur.ac;
    assign daa_a1     = daa_lo_fix ? ({1'b0, cur.acc} + DAA_LO_ADJ) : {1'b0, cur.acc};
    assign daa_ac     = daa_lo_fix ? (cur.acc[3:0] > NIBBLE_MAX) : cur.ac;
    assign daa_cy1    = cur.cy | daa_a1[8];
    assign daa_hi_fix = (daa_a1[7:4] > NIBBLE_MAX) || daa_cy1;
    assign daa_a2     = daa_hi_fix ? ({1'b0, daa_a1[7:0]} + DAA_HI_ADJ)
                                   : {1'b0, daa_a1[7:0]};
    assign daa_cy     = daa_cy1 | daa_a2[8];

    always_comb
    begin
        nxt      = cur;
        wr_other = 1'b0;
        wr_val   = inr_val;
        case (action_t'(action))
            ACT_ADD, ACT_ADC:
            begin
                nxt.acc = sum9[7:0];
                nxt.cy  = sum9[8];
                nxt.ac  = nib_sum[4];
                nxt     = set_szp(nxt, sum9[7:0]);
            end
            ACT_SUB, ACT_SBB:
            begin
                nxt.acc = diff9[7:0];
                nxt.cy  = diff9[8];
                nxt.ac  = nib_diff[4];
                nxt     = set_szp(nxt, diff9[7:0]);
            end
            ACT_CMP:
            begin
                nxt.cy = diff9[8];
                nxt.ac = nib_diff[4];
                nxt    = set_szp(nxt, diff9[7:0]);
            end
            ACT_AND:
            begin
                nxt.acc = and_val;
                nxt.cy  = 1'b0;
                nxt.ac  = and_hc_mode & and_val[3];
                nxt     = set_szp(nxt, and_val);
            end
            ACT_XOR:
            begin
                nxt.acc = cur.acc ^ operand;
                nxt.cy  = 1'b0;
                nxt.ac  = 1'b0;
                nxt     = set_szp(nxt, cur.acc ^ operand);
            end
            ACT_OR:
            begin
                nxt.acc = cur.acc | operand;
                nxt.cy  = 1'b0;
                nxt.ac  = 1'b0;
                nxt     = set_szp(nxt, cur.acc | operand);
            end
            ACT_RLC:
            begin
                nxt.cy  = cur.acc[7];
                nxt.acc = {cur.acc[6:0], cur.acc[7]};
            end
            ACT_RRC:
            begin
                nxt.cy  = cur.acc[0];
                nxt.acc = {cur.acc[0], cur.acc[7:1]};
            end
            ACT_RAL:
            begin
                nxt.cy  = cur.acc[7];
                nxt.acc = {cur.acc[6:0], cur.cy};
            end
            ACT_RAR:
            begin
                nxt.cy  = cur.acc[0];
                nxt.acc = {cur.cy, cur.acc[7:1]};
            end
            ACT_CMA:
            begin
                nxt.acc = ~cur.acc;
            end
            ACT_STC:
            begin
                nxt.cy = 1'b1;
            end
            ACT_CMC:
            begin
                nxt.cy = ~cur.cy;
            end
            ACT_DAA:
            begin
                nxt.acc = daa_a2[7:0];
                nxt.cy  = daa_cy;
                nxt.ac  = daa_ac;
                nxt     = set_szp(nxt, daa_a2[7:0]);
            end
            ACT_INR:
            begin
                nxt.ac   = (inr_val[3:0] == 4'h0);
                nxt      = set_szp(nxt, inr_val);
                wr_other = 1'b1;
                wr_val   = inr_val;
            end
            ACT_DCR:
            begin
                nxt.ac   = (operand[3:0] == 4'h0);
                nxt      = set_szp(nxt, dcr_val);
                wr_other = 1'b1;
                wr_val   = dcr_val;
            end
            ACT_LOAD:
            begin
                nxt.acc = operand;
            end
            default:
            begin
                // unused codes leave the state alone
                nxt = cur;
            end
        endcase
        written = wr_other ? wr_val : nxt.acc;
    end

endmodule

// ===== rtl/cpu8080_alu_flags.sv =====
// Top level of the 8080-class accumulator and flag unit with its register port.
// An accepted request is registered, then moves into the result register once that slot frees.
// Throughput: one request per cycle while results are taken; the accumulator and flag
// registers close the loop between consecutive requests through one pass of the operation logic.
// Reset (rst_n low, asynchronous): accumulator and flags clear, and_half_carry_mode is 1,
// both pipeline stages are empty.
`timescale 1ns / 1ps

module cpu8080_alu_flags
    import c80alu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [4:0]  action,
    input  logic [7:0]  operand,
    // result channel
    output logic        res_valid,
    input  logic        res_ready,
    output logic [7:0]  acc_out,
    output logic [7:0]  written_value,
    output logic        carry_out,
    output logic        half_carry_out,
    output logic        zero_out,
    output logic        sign_out,
    output logic        parity_out,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        req_valid_reg;
    logic [4:0]  act_reg;
    logic [7:0]  opd_reg;
    logic        res_valid_reg;
    alu_state_t  res_state_reg;
    logic [7:0]  res_written_reg;
    alu_state_t  state_reg;
    alu_state_t  state_next;
    logic [7:0]  written_next;
    logic        mode_reg;
    logic        advance;
    logic        cfg_write;

    // request moves into the result register when the result slot is free or draining
    assign advance   = req_valid_reg && (!res_valid_reg || res_ready);
    assign req_ready = !req_valid_reg || advance;

    assign cfg_write = psel && penable && pwrite && (paddr[2] == CFG_IDX_AND_HC);
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == CFG_IDX_AND_HC) ? {31'h0, mode_reg} : 32'h0;

    c80alu_exec u_exec (
        .action      (act_reg),
        .operand     (opd_reg),
        .and_hc_mode (mode_reg),
        .cur         (state_reg),
        .nxt         (state_next),
        .written     (written_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '0;
            mode_reg      <= 1'b1;
        end
        else
        begin
            if (req_ready)
            begin
                req_valid_reg <= req_valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                mode_reg <= pwdata[0];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            act_reg <= action;
            opd_reg <= operand;
        end
        if (advance)
        begin
            res_state_reg   <= state_next;
            res_written_reg <= written_next;
        end
    end

    assign res_valid      = res_valid_reg;
    assign acc_out        = res_state_reg.acc;
    assign written_value  = res_written_reg;
    assign carry_out      = res_state_reg.cy;
    assign half_carry_out = res_state_reg.ac;
    assign zero_out       = res_state_reg.z;
    assign sign_out       = res_state_reg.s;
    assign parity_out     = res_state_reg.p;

`ifndef ASSERT_OFF
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid_reg && res_valid_reg && !res_ready) |-> !req_ready)
        else $error("request stage accepts while both stages are stalled");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("accumulator or flags changed without a request");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("result register not filled after a request moved on");

    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_state_reg == state_reg))
        else $error("pending result differs from the architectural state");
`endif

endmodule

// ===== tb/cpu8080_alu_flags_checker.sv =====
// Checker for the accumulator and flag unit: predicts each request's result and compares.
`timescale 1ns / 1ps

module cpu8080_alu_flags_checker
    import c80alu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  logic [4:0]  action,
    input  logic [7:0]  operand,
    input  logic        res_valid,
    input  logic        res_ready,
    input  logic [7:0]  acc_out,
    input  logic [7:0]  written_value,
    input  logic        carry_out,
    input  logic        half_carry_out,
    input  logic        zero_out,
    input  logic        sign_out,
    input  logic        parity_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          errors,
    output int          pending,
    output int          checked
);

    localparam int MAX_PRINTED = 50;

    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] wr;
        logic       cy;
        logic       ac;
        logic       z;
        logic       s;
        logic       p;
    } alu_outcome_t;

    alu_state_t   alu_q;
    logic         and_hc_mode;
    alu_outcome_t expected_outcomes[$];

    initial begin
        errors  = 0;
        pending = 0;
        checked = 0;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        if (errors < MAX_PRINTED)
            $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        errors++;
    endtask

    task automatic set_zsp(input logic [7:0] v);
        alu_q.z = (v == 8'h00);
        alu_q.s = v[7];
        alu_q.p = ~^v;
    endtask

    // one ALU step: updates the predicted accumulator/flags and queues the outcome
    task automatic predict_alu_step(input logic [4:0] act, input logic [7:0] b);
        logic [7:0]   a;
        logic [7:0]   diff;
        logic [7:0]   wr;
        logic [8:0]   sum;
        logic [8:0]   adj;
        logic [4:0]   lo;
        logic         cin;
        logic         wrote_other;
        alu_outcome_t outcome;
        a = alu_q.acc;
        wr = 8'h00;
        wrote_other = 1'b0;
        case (act)
            ACT_ADD, ACT_ADC:
            begin
                cin = (act == ACT_ADC) ? alu_q.cy : 1'b0;
                sum = {1'b0, a} + {1'b0, b} + {8'h00, cin};
                lo = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cin};
                alu_q.ac = lo[4];
                alu_q.cy = sum[8];
                alu_q.acc = sum[7:0];
                set_zsp(alu_q.acc);
            end
            ACT_SUB, ACT_SBB, ACT_CMP:
            begin
                cin = (act == ACT_SBB) ? alu_q.cy : 1'b0;
                alu_q.ac = ({1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'h0, cin}));
                alu_q.cy = ({1'b0, a} < ({1'b0, b} + {8'h00, cin}));
                diff = a - b - {7'h00, cin};
                if (act != ACT_CMP)
                    alu_q.acc = diff;
                set_zsp(diff);
            end
            ACT_AND:
            begin
                alu_q.acc = a & b;
                alu_q.cy = 1'b0;
                alu_q.ac = and_hc_mode ? alu_q.acc[3] : 1'b0;
                set_zsp(alu_q.acc);
            end
            ACT_XOR, ACT_OR:
            begin
                alu_q.acc = (act == ACT_XOR) ? (a ^ b) : (a | b);
                alu_q.cy = 1'b0;
                alu_q.ac = 1'b0;
                set_zsp(alu_q.acc);
            end
            ACT_RLC:
            begin
                alu_q.cy = a[7];
                alu_q.acc = {a[6:0], a[7]};
            end
            ACT_RRC:
            begin
                alu_q.cy = a[0];
                alu_q.acc = {a[0], a[7:1]};
            end
            ACT_RAL:
            begin
                alu_q.acc = {a[6:0], alu_q.cy};
                alu_q.cy = a[7];
            end
            ACT_RAR:
            begin
                alu_q.acc = {alu_q.cy, a[7:1]};
                alu_q.cy = a[0];
            end
            ACT_CMA: alu_q.acc = ~a;
            ACT_STC: alu_q.cy = 1'b1;
            ACT_CMC: alu_q.cy = ~alu_q.cy;
            ACT_DAA:
            begin
                adj = {1'b0, a};
                if (a[3:0] > 4'd9 || alu_q.ac)
                begin
                    alu_q.ac = (a[3:0] > 4'd9);
                    adj = adj + 9'h006;
                    if (adj[8])
                        alu_q.cy = 1'b1;
                    adj[8] = 1'b0;
                end
                if (adj[7:4] > 4'd9 || alu_q.cy)
                begin
                    adj = adj + 9'h060;
                    if (adj[8])
                        alu_q.cy = 1'b1;
                end
                alu_q.acc = adj[7:0];
                set_zsp(alu_q.acc);
            end
            ACT_INR:
            begin
                wr = b + 8'd1;
                alu_q.ac = (wr[3:0] == 4'h0);
                set_zsp(wr);
                wrote_other = 1'b1;
            end
            ACT_DCR:
            begin
                wr = b - 8'd1;
                alu_q.ac = (b[3:0] == 4'h0);
                set_zsp(wr);
                wrote_other = 1'b1;
            end
            ACT_LOAD: alu_q.acc = b;
            default: ;  // unused codes leave everything as is
        endcase
        outcome.acc = alu_q.acc;
        outcome.wr  = wrote_other ? wr : alu_q.acc;
        outcome.cy  = alu_q.cy;
        outcome.ac  = alu_q.ac;
        outcome.z   = alu_q.z;
        outcome.s   = alu_q.s;
        outcome.p   = alu_q.p;
        expected_outcomes.push_back(outcome);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        alu_outcome_t exp_out;
        if (!rst_n)
        begin
            alu_q = '0;
            and_hc_mode = 1'b1;
            expected_outcomes.delete();
            pending <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (expected_outcomes.size() == 0)
                    report("result with no request outstanding", {24'h0, acc_out}, 32'h0);
                else
                begin
                    exp_out = expected_outcomes.pop_front();
                    if (acc_out !== exp_out.acc)
                        report("acc_out", {24'h0, acc_out}, {24'h0, exp_out.acc});
                    if (written_value !== exp_out.wr)
                        report("written_value", {24'h0, written_value}, {24'h0, exp_out.wr});
                    if (carry_out !== exp_out.cy)
                        report("carry_out", {31'h0, carry_out}, {31'h0, exp_out.cy});
                    if (half_carry_out !== exp_out.ac)
                        report("half_carry_out", {31'h0, half_carry_out}, {31'h0, exp_out.ac});
                    if (zero_out !== exp_out.z)
                        report("zero_out", {31'h0, zero_out}, {31'h0, exp_out.z});
                    if (sign_out !== exp_out.s)
                        report("sign_out", {31'h0, sign_out}, {31'h0, exp_out.s});
                    if (parity_out !== exp_out.p)
                        report("parity_out", {31'h0, parity_out}, {31'h0, exp_out.p});
                    checked <= checked + 1;
                end
            end
            if (req_valid && req_ready)
                predict_alu_step(action, operand);
            if (psel && penable && pready && paddr[2] == CFG_IDX_AND_HC)
            begin
                if (pwrite)
                    and_hc_mode = pwdata[0];
                else if (prdata !== {31'h0, and_hc_mode})
                    report("prdata", prdata, {31'h0, and_hc_mode});
            end
            pending <= expected_outcomes.size();
        end
    end

endmodule

// ===== tb/cpu8080_alu_flags_test.sv =====
// Testbench top for the accumulator and flag unit: stimulus, register setup and verdict.
`timescale 1ns / 1ps

module cpu8080_alu_flags_test;
    import c80alu_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_AT      = 700;
    localparam int HOLD_CYCLES  = 150;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 325;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    logic [4:0]  action;
    logic [7:0]  operand;
    logic        res_valid;
    logic        res_ready;
    logic [7:0]  acc_out;
    logic [7:0]  written_value;
    logic        carry_out;
    logic        half_carry_out;
    logic        zero_out;
    logic        sign_out;
    logic        parity_out;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int pending;
    int checked;
    bit no_idle;
    int idle_cycles;

    cpu8080_alu_flags DUT (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .action(action), .operand(operand),
        .res_valid(res_valid), .res_ready(res_ready), .acc_out(acc_out),
        .written_value(written_value), .carry_out(carry_out),
        .half_carry_out(half_carry_out), .zero_out(zero_out), .sign_out(sign_out),
        .parity_out(parity_out),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    cpu8080_alu_flags_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .action(action), .operand(operand),
        .res_valid(res_valid), .res_ready(res_ready), .acc_out(acc_out),
        .written_value(written_value), .carry_out(carry_out),
        .half_carry_out(half_carry_out), .zero_out(zero_out), .sign_out(sign_out),
        .parity_out(parity_out),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .errors(errors), .pending(pending), .checked(checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // nothing accepted for too long means the block is hung
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (res_valid && res_ready) || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: nothing accepted for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [7:0] rand_byte();
        if ($urandom_range(0, 3) != 0)
            return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hff;
            2: return 8'h0f;
            3: return 8'h10;
            4: return 8'h7f;
            5: return 8'h80;
            6: return 8'h01;
            default: return 8'h99;
        endcase
    endfunction

    task automatic send(input logic [4:0] act, input logic [7:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        action <= act;
        operand <= b;
        do @(posedge clk); while (!req_ready);
    endtask

    // lower valid and wait until every outstanding request has its result
    task automatic drain();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {CFG_IDX_AND_HC, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reg_read();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {CFG_IDX_AND_HC, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_directed();
        send(ACT_LOAD, 8'hff);
        send(ACT_ADD, 8'h01);   // carry, half-carry and zero together
        send(ACT_ADC, 8'h00);   // carry in
        send(ACT_LOAD, 8'h00);
        send(ACT_SUB, 8'h01);   // borrow from both nibbles
        send(ACT_SBB, 8'hff);   // borrow in on top of maximum operand
        send(ACT_CMP, 8'h80);
        send(ACT_LOAD, 8'h3c);
        send(ACT_AND, 8'h0f);   // half-carry from result bit 3
        send(ACT_XOR, 8'hff);
        send(ACT_OR, 8'h00);
        send(ACT_RLC, 8'h00);
        send(ACT_RRC, 8'hff);   // carry from bit 0
        send(ACT_RAL, 8'h00);
        send(ACT_RAR, 8'h00);
        send(ACT_CMA, 8'h00);
        send(ACT_STC, 8'h00);
        send(ACT_CMC, 8'h00);
        send(ACT_LOAD, 8'h9b);
        send(ACT_DAA, 8'h00);   // both nibbles adjust, carry out
        send(ACT_INR, 8'hff);   // written value wraps, accumulator untouched
        send(ACT_DCR, 8'h00);
        send(ACT_DCR, 8'h10);   // low-nibble borrow
        send(ACT_INR, 8'h0f);
        send(5'd31, 8'hff);     // unused code
    endtask

    task automatic run_random(input int count);
        int k;
        int next_seg;
        int pick;
        logic [3:0] d1, d0, e1, e0;
        k = 0;
        next_seg = 0;
        while (k < count)
        begin
            if (k >= next_seg)
            begin
                no_idle = ($urandom_range(0, 3) == 0);
                next_seg = next_seg + 50;
            end
            pick = $urandom_range(0, 9);
            if (pick < 2)
            begin
                // packed-BCD addition followed by decimal adjust
                d1 = 4'($urandom_range(0, 9));
                d0 = 4'($urandom_range(0, 9));
                e1 = 4'($urandom_range(0, 9));
                e0 = 4'($urandom_range(0, 9));
                send(ACT_LOAD, {d1, d0});
                send(($urandom_range(0, 1) != 0) ? ACT_ADD : ACT_ADC, {e1, e0});
                send(ACT_DAA, rand_byte());
                k = k + 3;
            end
            else
            begin
                if (pick == 2)
                    send(5'($urandom_range(19, 31)), rand_byte());
                else
                    send(5'($urandom_range(0, 18)), rand_byte());
                k++;
            end
        end
        no_idle = 1'b0;
    endtask

    // result side: random stalls, one long hold-off to back the block up
    initial
    begin : result_sink
        int gap;
        int taken;
        taken = 0;
        res_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 9);
            if (taken == HOLD_AT)
                gap = HOLD_CYCLES;
            if (gap > 0)
            begin
                res_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
            taken++;
        end
    end

    initial
    begin : stimulus
        int ph;
        idle_cycles = 0;
        no_idle = 1'b0;
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        action <= ACT_ADD;
        operand <= 8'h00;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        reg_read();     // reset value of the mode bit
        reg_write(32'h1);
        run_directed();
        drain();

        for (ph = 0; ph < PHASES; ph++)
        begin
            reg_write((ph % 2 == 0) ? 32'h0 : 32'h1);
            reg_read();
            run_random(PHASE_ITEMS);
            drain();
        end

        $display("Checked %0d results: all operations, unused codes, BCD add/adjust chains,",
                 checked);
        $display("both AND half-carry modes, random idling and a %0d-cycle result stall.",
                 HOLD_CYCLES);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
